@@ rtl/fhdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fhdp_pkg;
    localparam int MAX_STAGES  = 16;
    localparam int GRID_STATES = 16;

    localparam int COST_W = 12;
    localparam logic signed [COST_W-1:0] COST_LO = 12'sh800;
    localparam logic signed [COST_W-1:0] COST_HI = 12'sh7FF;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic [2:0] REG_STATE_MIN    = 3'd0;
    localparam logic [2:0] REG_STATE_MAX    = 3'd1;
    localparam logic [2:0] REG_FINAL_MIN    = 3'd2;
    localparam logic [2:0] REG_FINAL_TARGET = 3'd3;
    localparam logic [2:0] REG_CONTROL_MAX  = 3'd4;
    localparam logic [2:0] REG_HORIZON      = 3'd5;

    typedef struct packed {
        logic       op;
        logic [3:0] stage_index;
        logic [3:0] disturbance;
        logic [3:0] initial_state;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        out_stage;
        logic [3:0]        out_state;
        logic [1:0]        out_control;
        logic [COST_W-1:0] cost_to_go;
        logic              feasible;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [3:0] state_min;
        logic [3:0] state_max;
        logic [3:0] final_min;
        logic [3:0] final_target;
        logic [1:0] control_max;
        logic [3:0] horizon;
    } cfg_t;
endpackage
`default_nettype wire

@@ rtl/finite_horizon_dp_solver_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Backward dynamic-programming solver over a small integer state grid.
// Input channel s_*: a load request (op = 0) writes one stage disturbance.
// A solve request (op = 1) runs a backward pass, then a forward pass that
// returns one result per decision stage on m_*.
// The final stage visits every grid state in ST_TERM and ST_TERM_WR. Each earlier
// stage passes states outside [state_min, state_max] through ST_STATE and ST_WRITE
// only; for a state inside it, each control 0..control_max is a candidate, tried in
// ST_READ and ST_EVAL through a shared cost unit with a registered table read in
// between. The forward pass steps through ST_FWD_RD and ST_FWD_OUT per result,
// then ST_FWD_WAIT releases the block.
// s_ready is low while a request is in work; configuration writes on cfg_*
// are taken in any cycle and are meant for an idle block.
// The last result carries last = 1; an infeasible result ends the run early.
// A stalled receiver holds the result register and the sequencer waits.
// Reset (aresetn low, synchronous) restores register defaults and clears the
// disturbance store; the cost, policy and entry-valid tables hold no reset
// value, since a solve rewrites every entry it later reads.
module finite_horizon_dp_solver_unit
    import fhdp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [3:0] cfg_data
);
    localparam int SW    = $clog2(MAX_STAGES);
    localparam int GW    = $clog2(GRID_STATES);
    localparam int DEPTH = MAX_STAGES * GRID_STATES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = 7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TERM, ST_TERM_WR, ST_STATE, ST_READ, ST_EVAL,
        ST_WRITE, ST_FWD_RD, ST_FWD_OUT, ST_FWD_WAIT
    } state_t;

    state_t state_reg;
    cfg_t   cfg_reg;
    logic [3:0] dist_reg [MAX_STAGES];
    logic vld_mem [DEPTH];
    logic signed [COST_W-1:0] cost_mem [DEPTH];
    logic [1:0] pol_mem [DEPTH];

    logic [SW-1:0] h_reg, k_reg;
    logic [GW-1:0] s_reg;
    logic [1:0]    u_reg;
    logic [3:0]    cur_reg;
    logic          found_reg;
    logic signed [COST_W-1:0] best_reg;
    logic [1:0]    bu_reg;
    logic signed [COST_W-1:0] rd_cost_reg;
    logic [1:0]    rd_pol_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_addr;
    logic          cand_ok_reg;
    out_item_t     out_reg;
    logic          out_valid_reg;

    logic          alu_term;
    logic [5:0]    alu_a, alu_b;
    logic signed [COST_W-1:0] alu_res;

    logic [4:0] eff_h;
    logic signed [NW-1:0] nxt;
    logic [3:0] fwd_nxt;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        eff_h = {1'b0, cfg_reg.horizon};
        if (eff_h < 5'd1) begin
            eff_h = 5'd1;
        end
        if (32'(eff_h) > MAX_STAGES - 1) begin
            eff_h = 5'(MAX_STAGES - 1);
        end
        nxt = NW'(s_reg) - NW'(u_reg) + NW'(dist_reg[k_reg]);
        fwd_nxt = cur_reg - 4'(rd_pol_reg) + dist_reg[k_reg];
    end

    fhdp_cost_alu u_alu (
        .terminal(alu_term),
        .a_val   (alu_a),
        .b_val   (alu_b),
        .base    (rd_cost_reg),
        .result  (alu_res)
    );

    always_comb begin
        alu_term = (state_reg == ST_TERM_WR);
        if (alu_term) begin
            alu_a = 6'(s_reg);
            alu_b = 6'(cfg_reg.final_target);
        end else begin
            alu_a = 6'(s_reg);
            alu_b = 6'(u_reg);
        end
        rd_addr = AW'(32'(k_reg + SW'(1)) * GRID_STATES + 32'(nxt[GW-1:0]));
        if (state_reg == ST_FWD_RD || state_reg == ST_FWD_OUT) begin
            rd_addr = AW'(32'(k_reg) * GRID_STATES + 32'(cur_reg));
        end
    end

    always_ff @(posedge aclk) begin
        rd_cost_reg <= cost_mem[rd_addr];
        rd_pol_reg  <= pol_mem[rd_addr];
        rd_vld_reg  <= vld_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= '{state_min: 4'd3, state_max: 4'd8, final_min: 4'd6,
                               final_target: 4'd8, control_max: 2'd2, horizon: 4'd10};
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                dist_reg[i] <= 4'd0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_STATE_MIN:    cfg_reg.state_min    <= cfg_data;
                    REG_STATE_MAX:    cfg_reg.state_max    <= cfg_data;
                    REG_FINAL_MIN:    cfg_reg.final_min    <= cfg_data;
                    REG_FINAL_TARGET: cfg_reg.final_target <= cfg_data;
                    REG_CONTROL_MAX:  cfg_reg.control_max  <= cfg_data[1:0];
                    REG_HORIZON:      cfg_reg.horizon      <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready && state_reg != ST_FWD_OUT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.op == OP_LOAD) begin
                            if (32'(s_data.stage_index) < MAX_STAGES) begin
                                dist_reg[SW'(s_data.stage_index)] <= s_data.disturbance;
                            end
                        end else begin
                            h_reg     <= SW'(eff_h);
                            k_reg     <= SW'(eff_h);
                            s_reg     <= '0;
                            cur_reg   <= s_data.initial_state;
                            state_reg <= ST_TERM;
                        end
                    end
                end
                ST_TERM: begin
                    state_reg <= ST_TERM_WR;
                end
                ST_TERM_WR: begin
                    if (32'(s_reg) >= 32'(cfg_reg.final_min)
                        && 32'(s_reg) <= 32'(cfg_reg.state_max)) begin
                        cost_mem[AW'(32'(h_reg) * GRID_STATES + 32'(s_reg))] <= alu_res;
                        pol_mem[AW'(32'(h_reg) * GRID_STATES + 32'(s_reg))]  <= 2'd0;
                        vld_mem[AW'(32'(h_reg) * GRID_STATES + 32'(s_reg))]  <= 1'b1;
                    end else begin
                        vld_mem[AW'(32'(h_reg) * GRID_STATES + 32'(s_reg))]  <= 1'b0;
                    end
                    if (32'(s_reg) == GRID_STATES - 1) begin
                        s_reg     <= '0;
                        k_reg     <= h_reg - SW'(1);
                        state_reg <= ST_STATE;
                    end else begin
                        s_reg     <= s_reg + GW'(1);
                        state_reg <= ST_TERM;
                    end
                end
                ST_STATE: begin
                    u_reg     <= 2'd0;
                    found_reg <= 1'b0;
                    if (32'(s_reg) < 32'(cfg_reg.state_min)
                        || 32'(s_reg) > 32'(cfg_reg.state_max)) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    cand_ok_reg <= (nxt >= 0) && (32'(nxt) < GRID_STATES);
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (cand_ok_reg && rd_vld_reg
                        && (!found_reg || alu_res < best_reg)) begin
                        found_reg <= 1'b1;
                        best_reg  <= alu_res;
                        bu_reg    <= u_reg;
                    end
                    if (u_reg == cfg_reg.control_max) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        u_reg     <= u_reg + 2'd1;
                        state_reg <= ST_READ;
                    end
                end
                ST_WRITE: begin
                    if (found_reg) begin
                        cost_mem[AW'(32'(k_reg) * GRID_STATES + 32'(s_reg))] <= best_reg;
                        pol_mem[AW'(32'(k_reg) * GRID_STATES + 32'(s_reg))]  <= bu_reg;
                    end
                    vld_mem[AW'(32'(k_reg) * GRID_STATES + 32'(s_reg))] <= found_reg;
                    if (32'(s_reg) == GRID_STATES - 1) begin
                        s_reg <= '0;
                        if (k_reg == '0) begin
                            state_reg <= ST_FWD_RD;
                        end else begin
                            k_reg     <= k_reg - SW'(1);
                            state_reg <= ST_STATE;
                        end
                    end else begin
                        s_reg     <= s_reg + GW'(1);
                        state_reg <= ST_STATE;
                    end
                end
                ST_FWD_RD: begin
                    state_reg <= ST_FWD_OUT;
                end
                ST_FWD_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg      <= 1'b1;
                        out_reg.out_stage  <= 4'(k_reg);
                        out_reg.out_state  <= cur_reg;
                        if (rd_vld_reg) begin
                            out_reg.out_control <= rd_pol_reg;
                            out_reg.cost_to_go  <= rd_cost_reg;
                            out_reg.feasible    <= 1'b1;
                            out_reg.last        <= (k_reg + SW'(1) == h_reg);
                        end else begin
                            out_reg.out_control <= 2'd0;
                            out_reg.cost_to_go  <= '0;
                            out_reg.feasible    <= 1'b0;
                            out_reg.last        <= 1'b1;
                        end
                        if (!rd_vld_reg || k_reg + SW'(1) == h_reg) begin
                            state_reg <= ST_FWD_WAIT;
                        end else begin
                            cur_reg   <= fwd_nxt;
                            k_reg     <= k_reg + SW'(1);
                            state_reg <= ST_FWD_RD;
                        end
                    end
                end
                ST_FWD_WAIT: begin
                    if (!out_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/fhdp_cost_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fhdp_cost_alu
    import fhdp_pkg::*;
(
    input  wire logic                     terminal,
    input  wire logic [5:0]               a_val,
    input  wire logic [5:0]               b_val,
    input  wire logic signed [COST_W-1:0] base,
    output logic signed [COST_W-1:0]      result
);
    logic signed [6:0]  diff;
    logic signed [14:0] prod;
    logic signed [15:0] sum;

    always_comb begin
        diff = signed'({1'b0, a_val}) - signed'({1'b0, b_val});
        if (terminal) begin
            prod = 15'(diff * diff);
            sum  = 16'(prod) * 16'sd5;
        end else begin
            prod = 15'(signed'({1'b0, a_val}) * signed'({1'b0, b_val}));
            sum  = 16'(base) - 16'(prod);
        end
        if (sum < 16'(COST_LO)) begin
            result = COST_LO;
        end else if (sum > 16'(COST_HI)) begin
            result = COST_HI;
        end else begin
            result = sum[COST_W-1:0];
        end
    end
endmodule
`default_nettype wire
